### src/lcst_pkg.sv
// ----------------------------------------------------------------------------
// lcst_pkg
// Shared types and constants for the LRU cache set tag store.
// ----------------------------------------------------------------------------
package lcst_pkg;

  // request command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  // ways_in_use register
  localparam int          WAYS_IN_USE_W     = 4;
  localparam logic [3:0]  WAYS_IN_USE_RESET = 4'd8;

  // result way field width
  localparam int          OUT_WAY_W = 3;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture an accepted request
    logic look;   // tag compare and victim select
    logic upd;    // LRU/tag update and result load
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_status_t;

endpackage

### src/lru_cache_set_tag_store.sv
// ----------------------------------------------------------------------------
// lru_cache_set_tag_store
// One set of a set-associative cache: tag store with true LRU replacement.
// ----------------------------------------------------------------------------
// Each request runs a compare step, which checks the tag against all ways in
// use and picks the LRU victim, then an update step, which moves the selected
// way to the most recent end of the order list and writes the tag on a fill.
// A new request is taken during the update step of the last one. Results sit
// in an output register, and a stalled result holds the update step until
// taken. Tags reset to zero with no valid bits, so tag zero hits after reset.
// ----------------------------------------------------------------------------
module lru_cache_set_tag_store #(
  parameter int WAYS      = 8,
  parameter int TAG_WIDTH = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [3:0]           cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [TAG_WIDTH-1:0] tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [2:0]           way
);
  import lcst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer
  lcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tag store and LRU datapath
  lcst_datapath #(
    .WAYS      (WAYS),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .command        (command),
    .tag            (tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way            (way)
  );

endmodule

### src/lcst_ctrl.sv
// ----------------------------------------------------------------------------
// lcst_ctrl
// Sequencer: accept a request, run the compare step, then the update step.
// ----------------------------------------------------------------------------
module lcst_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lcst_pkg::dp_status_t   sts,
  output lcst_pkg::ctrl_cmd_t    cmd
);
  import lcst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  state_t state;

  // a new request may enter while the update of the last one completes
  assign in_ready = (state == ST_IDLE) || ((state == ST_UPD) && sts.out_free);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.look = (state == ST_LOOK);
    cmd.upd  = (state == ST_UPD) && sts.out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) state <= ST_LOOK;
        end
        ST_LOOK: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (sts.out_free) state <= cmd.load ? ST_LOOK : ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/lcst_datapath.sv
// ----------------------------------------------------------------------------
// lcst_datapath
// Tag array, LRU order list, request and result registers.
// ----------------------------------------------------------------------------
module lcst_datapath #(
  parameter int WAYS      = 8,
  parameter int TAG_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lcst_pkg::ctrl_cmd_t    cmd,
  output lcst_pkg::dp_status_t   sts,
  input  logic                   cfg_write_en,
  input  logic [3:0]             cfg_write_data,
  input  logic                   command,
  input  logic [TAG_WIDTH-1:0]   tag,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   hit,
  output logic [2:0]             way
);
  import lcst_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);

  // state
  logic [TAG_WIDTH-1:0]     way_tags  [WAYS];
  logic [WAY_W-1:0]         lru_order [WAYS];
  logic [WAYS_IN_USE_W-1:0] ways_in_use;

  // request registers
  logic                 cmd_q;
  logic [TAG_WIDTH-1:0] tag_q;

  // compare step results
  logic             hit_q;
  logic             fill_q;
  logic [WAY_W-1:0] sel_way;

  // result register
  logic             out_hit;
  logic [WAY_W-1:0] out_way;

  logic [CNT_W-1:0] active;
  logic             match_any;
  logic [WAY_W-1:0] match_way;
  logic [WAY_W-1:0] victim_way;
  logic [WAY_W-1:0] sel_pos;
  logic [WAY_W+2:0] way_ext;

  assign sts.out_free = !out_valid || out_ready;

  // clamp ways in use to 1 .. WAYS
  always_comb begin
    if (ways_in_use == '0) begin
      active = CNT_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      active = CNT_W'(WAYS);
    end else begin
      active = CNT_W'(ways_in_use);
    end
  end

  // lowest matching way among those in use
  always_comb begin
    match_any = 1'b0;
    match_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if ((i < int'(active)) && (way_tags[i] == tag_q)) begin
        match_any = 1'b1;
        match_way = WAY_W'(i);
      end
    end
  end

  // victim: entry nearest the least-recent end whose way is in use
  always_comb begin
    victim_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (int'(lru_order[i]) < int'(active)) victim_way = lru_order[i];
    end
  end

  // position of the selected way in the order list
  always_comb begin
    sel_pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (lru_order[i] == sel_way) sel_pos = WAY_W'(i);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= WAYS_IN_USE_RESET;
    end else if (cfg_write_en) begin
      ways_in_use <= cfg_write_data;
    end
  end

  // request capture and compare step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      tag_q <= tag;
    end
    if (cmd.look) begin
      if (cmd_q == CMD_FILL) begin
        hit_q   <= 1'b0;
        fill_q  <= 1'b1;
        sel_way <= victim_way;
      end else begin
        hit_q   <= match_any;
        fill_q  <= 1'b0;
        sel_way <= match_any ? match_way : '0;
      end
    end
  end

  // tag write and move of the selected way to most recent
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAYS; i++) begin
        way_tags[i]  <= '0;
        lru_order[i] <= WAY_W'(i);
      end
    end else if (cmd.upd && (hit_q || fill_q)) begin
      if (fill_q) way_tags[sel_way] <= tag_q;
      for (int i = 0; i < WAYS - 1; i++) begin
        if (i >= int'(sel_pos)) lru_order[i] <= lru_order[i + 1];
      end
      lru_order[WAYS-1] <= sel_way;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_hit <= hit_q;
      out_way <= sel_way;
    end
  end

  assign way_ext = {3'b000, out_way};
  assign hit     = out_hit;
  assign way     = way_ext[OUT_WAY_W-1:0];

  // the updated way lands at the most-recent end
  a_mru_after_update: assert property (@(posedge clk) disable iff (rst)
    cmd.upd && (hit_q || fill_q) |=> lru_order[WAYS-1] == $past(sel_way))
    else $error("updated way is not most recent");

  // a fill installs its tag in the victim way
  a_fill_writes_tag: assert property (@(posedge clk) disable iff (rst)
    cmd.upd && fill_q |=> way_tags[$past(sel_way)] == $past(tag_q))
    else $error("fill did not write the tag");

  // a hit reports a way inside the active range
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_hit |-> int'(out_way) < int'(active))
    else $error("hit way outside the ways in use");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU cache set tag store: a directed plan of
// lookups, fills and ways-in-use settings, then random phases over small tag
// pools. A behavioral copy of the set (tags, age order) predicts each result
// the plan does not fix; all are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcst_pkg::*;

  localparam int NUM_WAYS   = 8;
  localparam int TAG_W      = 20;
  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 102;
  localparam int POOL_SIZE  = 10;
  localparam int PLAN_ROWS  = 30;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
  } set_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one row of the directed plan; a known row carries its expected result
  typedef struct packed {
    row_kind_t                kind;
    logic                     cmd;
    logic [TAG_W-1:0]         tag;
    logic [WAYS_IN_USE_W-1:0] ways;
    logic                     known;
    logic                     hit;
    logic [OUT_WAY_W-1:0]     way;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset state: tag zero hits way 0, all-ones misses
    '{ROW_REQ, CMD_LOOKUP, 20'h00000, 4'd0, 1'b1, 1'b1, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'hFFFFF, 4'd0, 1'b1, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'hFFFFF, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'hFFFFF, 4'd0, 1'b0, 1'b0, 3'd0},
    // second copy of tag zero: lookup must pick the lowest way
    '{ROW_REQ, CMD_FILL,   20'h00000, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h00000, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'hAAAAA, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h55555, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h55555, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'hAAAAA, 4'd0, 1'b0, 1'b0, 3'd0},
    // zero ways in use acts as one way
    '{ROW_CFG, CMD_LOOKUP, 20'h00000, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h12345, 4'd0, 1'b1, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h12345, 4'd0, 1'b1, 1'b1, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'hFFFFF, 4'd0, 1'b1, 1'b0, 3'd0},
    // above the way count saturates to all ways
    '{ROW_CFG, CMD_LOOKUP, 20'h00000, 4'd15, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'hFFFFF, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h0F0F0, 4'd0, 1'b0, 1'b0, 3'd0},
    // partial range: victims skip ways outside it
    '{ROW_CFG, CMD_LOOKUP, 20'h00000, 4'd3, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h33333, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h44444, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h66666, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h77777, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h77777, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h12345, 4'd0, 1'b0, 1'b0, 3'd0},
    // single way: fill always lands in way 0
    '{ROW_CFG, CMD_LOOKUP, 20'h00000, 4'd1, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'h00001, 4'd0, 1'b1, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h00001, 4'd0, 1'b1, 1'b1, 3'd0},
    '{ROW_CFG, CMD_LOOKUP, 20'h00000, 4'd8, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_LOOKUP, 20'h00001, 4'd0, 1'b0, 1'b0, 3'd0},
    '{ROW_REQ, CMD_FILL,   20'hFFFFE, 4'd0, 1'b0, 1'b0, 3'd0}
  };

  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     cfg_write_en   = 1'b0;
  logic [WAYS_IN_USE_W-1:0] cfg_write_data = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic                     command        = CMD_LOOKUP;
  logic [TAG_W-1:0]         tag            = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic                     hit;
  logic [OUT_WAY_W-1:0]     way;

  // no-stall stretch for both sides
  bit quiet = 1'b0;
  int mismatches = 0;

  // shadow copy of the set
  logic [TAG_W-1:0]         shadow_tags  [NUM_WAYS];
  logic [OUT_WAY_W-1:0]     age_order    [NUM_WAYS];
  logic [WAYS_IN_USE_W-1:0] shadow_ways;

  set_result_t pending_results [$];

  lru_cache_set_tag_store #(
    .WAYS      (NUM_WAYS),
    .TAG_WIDTH (TAG_W)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .tag            (tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way            (way)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ways taking part: zero counts as one, above the way count saturates
  function automatic int unsigned active_span();
    if (shadow_ways == 0) return 1;
    if (shadow_ways > NUM_WAYS) return NUM_WAYS;
    return int'(shadow_ways);
  endfunction

  // move the entry at one position of the age order to the recent end
  function automatic void make_recent(int unsigned pos);
    logic [OUT_WAY_W-1:0] w;
    w = age_order[pos];
    for (int unsigned p = pos; p + 1 < NUM_WAYS; p++) age_order[p] = age_order[p + 1];
    age_order[NUM_WAYS - 1] = w;
  endfunction

  // apply one request to the shadow set and return its result
  function automatic set_result_t tag_store_access(logic cmd, logic [TAG_W-1:0] t);
    set_result_t  r;
    int unsigned  span;
    r = '0;
    span = active_span();
    if (cmd == CMD_LOOKUP) begin
      for (int unsigned w = 0; w < span; w++) begin
        if (shadow_tags[w] == t) begin
          for (int unsigned p = 0; p < NUM_WAYS; p++) begin
            if (age_order[p] == w) begin
              make_recent(p);
              break;
            end
          end
          r.hit = 1'b1;
          r.way = w[OUT_WAY_W-1:0];
          break;
        end
      end
    end else begin
      // victim: oldest entry whose way is inside the range
      for (int unsigned p = 0; p < NUM_WAYS; p++) begin
        if (age_order[p] < span) begin
          r.way = age_order[p];
          shadow_tags[age_order[p]] = t;
          make_recent(p);
          break;
        end
      end
    end
    return r;
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic issue_request(logic cmd, logic [TAG_W-1:0] t, bit known,
                               set_result_t typed);
    set_result_t predicted;
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    tag      <= t;
    do @(posedge clk); while (!in_ready);
    predicted = tag_store_access(cmd, t);
    if (known) predicted = typed;
    pending_results = {pending_results, predicted};
  endtask

  // write ways_in_use once the block has drained
  task automatic set_ways_in_use(logic [WAYS_IN_USE_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    shadow_ways = v;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0d way=%0d", hit, way);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit || way !== want.way) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: hit exp %0d got %0d, way exp %0d got %0d",
                     want.hit, hit, want.way, way);
        end
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= 37);
  end

  initial begin
    logic [TAG_W-1:0]         pool [POOL_SIZE];
    logic [WAYS_IN_USE_W-1:0] setting;
    logic                     cmd;
    logic [TAG_W-1:0]         t;
    set_result_t              typed;

    for (int w = 0; w < NUM_WAYS; w++) begin
      shadow_tags[w] = '0;
      age_order[w]   = w[OUT_WAY_W-1:0];
    end
    shadow_ways = WAYS_IN_USE_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        set_ways_in_use(PLAN[i].ways);
      end else begin
        typed.hit = PLAN[i].hit;
        typed.way = PLAN[i].way;
        issue_request(PLAN[i].cmd, PLAN[i].tag, PLAN[i].known, typed);
      end
    end

    // random phases, each with its own setting and a small tag pool
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = 4'd8;
        1: setting = 4'd1;
        2: setting = 4'd15;
        3: setting = 4'd0;
        4: setting = 4'd2;
        default: setting = WAYS_IN_USE_W'($urandom_range(15));
      endcase
      set_ways_in_use(setting);
      quiet <= (ph == 5);
      pool[0] = '0;
      pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) pool[k] = TAG_W'($urandom);
      for (int n = 0; n < PHASE_REQS; n++) begin
        cmd = ($urandom_range(99) < 55) ? CMD_LOOKUP : CMD_FILL;
        t = ($urandom_range(9) == 0) ? TAG_W'($urandom) : pool[$urandom_range(POOL_SIZE - 1)];
        issue_request(cmd, t, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lru_cache_set_tag_store regression: pass");
    end else begin
      $display("lru_cache_set_tag_store regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("lru_cache_set_tag_store regression: fail");
    $finish;
  end

endmodule
